// File: sv/tgard_pkg.sv
package tgard_pkg;

    // Pixel format codes
    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_RGB15  = 2'd1;
    localparam logic [1:0] FMT_BGR24  = 2'd2;
    localparam logic [1:0] FMT_BGRA32 = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PIXELS = 2'd2;

    // Register reset values
    localparam logic [1:0]            RST_PIXEL_FORMAT = FMT_BGR24;
    localparam logic                  RST_RLE_ENABLE   = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_TOTAL_PIXELS = 32'd1;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    // Entries between the byte parser and the pixel formatter
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [31:0] pix;        // gathered pixel bytes, first byte lowest
        logic [1:0]  fmt;
        logic        has_pixel;
        logic [7:0]  run;
        logic        done;
        logic        opaque;     // already gated by done
        logic        status;     // already gated by done
    } t_entry;

    // Expand a 5-bit channel to 8 bits
    function automatic logic [7:0] five_to_eight(input logic [4:0] v);
        logic [7:0] r;
        case (v)
            5'd0:  r = 8'd0;    5'd1:  r = 8'd8;    5'd2:  r = 8'd16;   5'd3:  r = 8'd25;
            5'd4:  r = 8'd33;   5'd5:  r = 8'd41;   5'd6:  r = 8'd49;   5'd7:  r = 8'd58;
            5'd8:  r = 8'd66;   5'd9:  r = 8'd74;   5'd10: r = 8'd82;   5'd11: r = 8'd90;
            5'd12: r = 8'd99;   5'd13: r = 8'd107;  5'd14: r = 8'd115;  5'd15: r = 8'd123;
            5'd16: r = 8'd132;  5'd17: r = 8'd140;  5'd18: r = 8'd148;  5'd19: r = 8'd156;
            5'd20: r = 8'd165;  5'd21: r = 8'd173;  5'd22: r = 8'd181;  5'd23: r = 8'd189;
            5'd24: r = 8'd197;  5'd25: r = 8'd206;  5'd26: r = 8'd214;  5'd27: r = 8'd222;
            5'd28: r = 8'd230;  5'd29: r = 8'd239;  5'd30: r = 8'd247;  5'd31: r = 8'd255;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/tgard_front.sv
module tgard_front
    import tgard_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_final,
    input  logic                  i_full,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic [1:0]            r_fmt, n_fmt;
    logic                  r_rle, n_rle;
    logic [CFG_DATA_W-1:0] r_total, n_total;

    logic [31:0] r_pix, n_pix;
    logic [1:0]  r_pos, n_pos;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_rep, n_pkt_rep;
    logic [31:0] r_pix_left, n_pix_left;
    logic        r_opaque, n_opaque;
    logic        r_finished, n_finished;

    logic        accept;
    logic        restart;
    logic [31:0] pix_cat;
    logic [1:0]  pos_inc;
    logic [7:0]  run_raw;
    logic [7:0]  run_clip;
    logic        opaque_upd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign restart = i_cfg_we && (i_cfg_idx == CFG_PIXEL_FORMAT ||
                                  i_cfg_idx == CFG_RLE_ENABLE ||
                                  i_cfg_idx == CFG_TOTAL_PIXELS);

    // Insert the new byte at its place in the gathered pixel
    always_comb begin
        pix_cat = r_pix;
        case (r_pos)
            2'd0:    pix_cat[7:0]   = i_byte;
            2'd1:    pix_cat[15:8]  = i_byte;
            2'd2:    pix_cat[23:16] = i_byte;
            default: pix_cat[31:24] = i_byte;
        endcase
    end

    assign pos_inc    = r_pos + 2'd1;
    assign run_raw    = (r_rle && r_pkt_rep) ? r_pkt_left : 8'd1;
    assign run_clip   = ({24'd0, run_raw} > r_pix_left) ? r_pix_left[7:0] : run_raw;
    assign opaque_upd = r_opaque && !(r_fmt == FMT_BGRA32 && i_byte != ALPHA_FULL);

    // Parse one byte: header, partial pixel, complete pixel, or image end once no pixels are left
    always_comb begin
        n_fmt      = r_fmt;
        n_rle      = r_rle;
        n_total    = r_total;
        n_pix      = r_pix;
        n_pos      = r_pos;
        n_pkt_left = r_pkt_left;
        n_pkt_rep  = r_pkt_rep;
        n_pix_left = r_pix_left;
        n_opaque   = r_opaque;
        n_finished = r_finished;
        o_push     = 1'b0;
        o_entry    = '0;
        o_entry.fmt = r_fmt;

        if (accept && !r_finished) begin
            if (r_pix_left == 32'd0) begin
                n_finished     = 1'b1;
                o_push         = 1'b1;
                o_entry.done   = 1'b1;
                o_entry.opaque = r_opaque;
            end else if (r_rle && r_pkt_left == 8'd0) begin
                n_pkt_left = {1'b0, i_byte[6:0]} + 8'd1;
                n_pkt_rep  = i_byte[7];
                if (i_final) begin
                    n_finished     = 1'b1;
                    o_push         = 1'b1;
                    o_entry.done   = 1'b1;
                    o_entry.opaque = r_opaque;
                    o_entry.status = 1'b1;
                end
            end else if (pos_inc != r_fmt + 2'd1) begin
                n_pix = pix_cat;
                n_pos = pos_inc;
                if (i_final) begin
                    n_finished     = 1'b1;
                    o_push         = 1'b1;
                    o_entry.done   = 1'b1;
                    o_entry.opaque = r_opaque;
                    o_entry.status = 1'b1;
                end
            end else begin
                n_pix      = '0;
                n_pos      = 2'd0;
                n_opaque   = opaque_upd;
                n_pix_left = r_pix_left - {24'd0, run_clip};
                if (r_rle && r_pkt_rep) begin
                    n_pkt_left = 8'd0;
                end else if (r_rle) begin
                    n_pkt_left = r_pkt_left - 8'd1;
                end
                o_push            = 1'b1;
                o_entry.pix       = pix_cat;
                o_entry.has_pixel = 1'b1;
                o_entry.run       = run_clip;
                if (n_pix_left == 32'd0 || i_final) begin
                    n_finished     = 1'b1;
                    o_entry.done   = 1'b1;
                    o_entry.opaque = opaque_upd;
                    o_entry.status = (n_pix_left != 32'd0);
                end
            end
        end

        // Register write restarts the image
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_FORMAT: n_fmt   = i_cfg_data[1:0];
                CFG_RLE_ENABLE:   n_rle   = i_cfg_data[0];
                CFG_TOTAL_PIXELS: n_total = i_cfg_data;
                default: ;
            endcase
        end
        if (restart) begin
            n_pix      = '0;
            n_pos      = 2'd0;
            n_pkt_left = 8'd0;
            n_pkt_rep  = 1'b0;
            n_pix_left = n_total;
            n_opaque   = 1'b1;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= RST_PIXEL_FORMAT;
            r_rle      <= RST_RLE_ENABLE;
            r_total    <= RST_TOTAL_PIXELS;
            r_pix      <= '0;
            r_pos      <= 2'd0;
            r_pkt_left <= 8'd0;
            r_pkt_rep  <= 1'b0;
            r_pix_left <= RST_TOTAL_PIXELS;
            r_opaque   <= 1'b1;
            r_finished <= 1'b0;
        end else begin
            r_fmt      <= n_fmt;
            r_rle      <= n_rle;
            r_total    <= n_total;
            r_pix      <= n_pix;
            r_pos      <= n_pos;
            r_pkt_left <= n_pkt_left;
            r_pkt_rep  <= n_pkt_rep;
            r_pix_left <= n_pix_left;
            r_opaque   <= n_opaque;
            r_finished <= n_finished;
        end
    end

`ifndef ASSERT_OFF
    a_done_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.done && !i_cfg_we) |=> r_finished)
        else $error("image end did not stop the parser");
    a_no_push_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !o_push)
        else $error("request pushed after image end");
    a_run_matches_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_entry.has_pixel == (o_entry.run != 8'd0)) &&
                   (o_entry.run <= 8'd128))
        else $error("run length inconsistent with pixel");
`endif

endmodule

// File: sv/tgard_queue.sv
module tgard_queue
    import tgard_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store requests
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= FULL_CNT) && !(i_push && o_full))
        else $error("queue overflow");
`endif

endmodule

// File: sv/tgard_back.sv
module tgard_back
    import tgard_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha,
    output logic [7:0] o_run,
    output logic   o_done,
    output logic   o_opaque,
    output logic   o_status
);

    logic       r_valid;
    logic [7:0] r_red, r_green, r_blue, r_alpha, r_run;
    logic       r_done, r_opaque, r_status;
    logic [7:0] c_red, c_green, c_blue, c_alpha;

    assign o_pop = i_valid && (!r_valid || i_ready);

    // Convert gathered bytes to RGBA
    always_comb begin
        c_red   = 8'd0;
        c_green = 8'd0;
        c_blue  = 8'd0;
        c_alpha = 8'd0;
        if (i_entry.has_pixel) begin
            c_alpha = ALPHA_FULL;
            case (i_entry.fmt)
                FMT_GRAY8: begin
                    c_red = i_entry.pix[7:0];
                end
                FMT_RGB15: begin
                    c_blue  = five_to_eight(i_entry.pix[4:0]);
                    c_green = five_to_eight(i_entry.pix[9:5]);
                    c_red   = five_to_eight(i_entry.pix[14:10]);
                end
                FMT_BGRA32: begin
                    c_blue  = i_entry.pix[7:0];
                    c_green = i_entry.pix[15:8];
                    c_red   = i_entry.pix[23:16];
                    c_alpha = i_entry.pix[31:24];
                end
                default: begin
                    c_blue  = i_entry.pix[7:0];
                    c_green = i_entry.pix[15:8];
                    c_red   = i_entry.pix[23:16];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red    <= c_red;
            r_green  <= c_green;
            r_blue   <= c_blue;
            r_alpha  <= c_alpha;
            r_run    <= i_entry.run;
            r_done   <= i_entry.done;
            r_opaque <= i_entry.opaque;
            r_status <= i_entry.status;
        end
    end

    assign o_valid  = r_valid;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_alpha  = r_alpha;
    assign o_run    = r_run;
    assign o_done   = r_done;
    assign o_opaque = r_opaque;
    assign o_status = r_status;

endmodule

// File: sv/tga_truecolor_rle_decoder.sv
// TGA true-color RLE pixel decoder. Feed the pixel-data bytes of an image one per cycle on
// the slave stream (byte in tdata, tlast on the last byte available); decoded RGBA pixels come
// out on the master stream, each with a run length, tlast on the result that completes or
// ends the image. One byte is taken every cycle as long as the queue between the byte
// parser and the pixel formatter has room; the parser updates its state for every byte it
// takes, which sets that rate. A completed result is written into the queue and then loaded
// into the formatter's output register. Configure format, RLE mode and pixel total through
// the write port while the stream is idle; any register write restarts the image.
module tga_truecolor_rle_decoder
    import tgard_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // data_byte
    input  logic                  i_s_axis_tlast,   // final_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] run_length
    output logic [39:0]           o_m_axis_tdata,
    output logic                  o_m_axis_tlast,   // image_done
    output logic [1:0]            o_m_axis_tuser    // [0] all_opaque, [1] status
);

    logic   push, full, pop, q_valid;
    t_entry push_entry, head_entry;
    logic [7:0] red, green, blue, alpha, run;
    logic   opaque, status;

    tgard_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_final    (i_s_axis_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    tgard_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    tgard_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_red    (red),
        .o_green  (green),
        .o_blue   (blue),
        .o_alpha  (alpha),
        .o_run    (run),
        .o_done   (o_m_axis_tlast),
        .o_opaque (opaque),
        .o_status (status)
    );

    assign o_m_axis_tdata = {run, alpha, blue, green, red};
    assign o_m_axis_tuser = {status, opaque};

endmodule
